// ===== design/cpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

    // Field widths of the point and result formats
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = SQ_W + 2;
    localparam int IDX_OUT_W = 6;

    // Number of register stages in the distance unit, drained after each scan
    localparam int DRAIN_LEN = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [DIST_W-1:0]  t_dist;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/closest_pair_of_points.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Closest pair of points. Points arrive one per request with signed Q7.8
// coordinates and are kept in a ring of MAX_POINTS cells in load order. Each
// stored point passes, between its accept and the next accept, through the
// accept, one rotation of the ring past a single pipelined squared-distance
// unit, the unit drain and the set bookkeeping; the new point is written into
// the ring during that same rotation. A point that arrives with the store full
// is dropped and flagged. The request marked tlast yields one result with the
// smallest squared distance (Q18.16), the indices of the first such pair in
// index order and the overflow flag; the set is then emptied. That request is
// held in the bookkeeping state for as long as the previous result is still
// unread. With fewer than two points found is 0 and distance and indices are
// 0. Indices are given modulo 64.

module closest_pair_of_points
    import cpp_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,  // [15:0] x_coord, [31:16] y_coord
    input  wire         i_s_axis_tlast,  // last_point
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata   // [0] found, [34:1] min_sq_dist,
                                         // [40:35] first_index, [46:41] second_index,
                                         // [47] overflowed
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_step, n_step;
    logic [1:0]         r_drain, n_drain;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_last, n_last;
    t_dist              r_best_d, n_best_d;
    logic [IDX_W-1:0]   r_best_f, n_best_f;
    logic [IDX_W-1:0]   r_best_s, n_best_s;
    t_coord             r_nx;
    t_coord             r_ny;
    logic               r_out_valid;
    logic [47:0]        r_out_data;

    logic               w_accept;
    logic               w_load_pt;
    logic               w_shift;
    logic               w_issue;
    logic               w_emit;
    logic               w_inject;
    logic               w_found;
    logic               w_d_valid;
    logic [IDX_W-1:0]   w_d_idx;
    t_dist              w_d_dist;
    logic [IDX_W+IDX_OUT_W-1:0] w_first_ext;
    logic [IDX_W+IDX_OUT_W-1:0] w_second_ext;
    t_coord             w_cx [MAX_POINTS];
    t_coord             w_cy [MAX_POINTS];
    t_coord             w_tail_x;
    t_coord             w_tail_y;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Ring of point cells; the head feeds the distance unit and wraps to the tail
    assign w_inject = (CNT_W'(r_step) == r_count);
    assign w_tail_x = w_inject ? r_nx : w_cx[0];
    assign w_tail_y = w_inject ? r_ny : w_cy[0];

    generate
        for (genvar k = 0; k < MAX_POINTS; k++) begin : g_ring
            if (k == MAX_POINTS - 1) begin : g_tail
                cpp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_x     (w_tail_x),
                    .i_y     (w_tail_y),
                    .o_x     (w_cx[k]),
                    .o_y     (w_cy[k])
                );
            end else begin : g_body
                cpp_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_x     (w_cx[k+1]),
                    .i_y     (w_cy[k+1]),
                    .o_x     (w_cx[k]),
                    .o_y     (w_cy[k])
                );
            end
        end
    endgenerate

    cpp_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_issue),
        .i_idx   (r_step),
        .i_ax    (w_cx[0]),
        .i_ay    (w_cy[0]),
        .i_bx    (r_nx),
        .i_by    (r_ny),
        .o_valid (w_d_valid),
        .o_idx   (w_d_idx),
        .o_dist  (w_d_dist)
    );

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence a point: scan the ring, drain the unit, settle the set; drop if full
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_drain         = r_drain;
        n_count         = r_count;
        n_ovf           = r_ovf;
        n_last          = r_last;
        w_load_pt       = 1'b0;
        w_shift         = 1'b0;
        w_issue         = 1'b0;
        w_emit          = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    w_load_pt = 1'b1;
                    n_last    = i_s_axis_tlast;
                    if (r_count == CNT_W'(MAX_POINTS)) begin
                        n_ovf   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_step  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_shift = 1'b1;
                w_issue = (CNT_W'(r_step) < r_count);
                n_step  = r_step + 1'b1;
                if (r_step == IDX_W'(MAX_POINTS - 1)) begin
                    n_drain = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == 2'(DRAIN_LEN - 1)) begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || i_m_axis_tready) begin
                    w_emit  = 1'b1;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Track the best pair; a tie goes to the lower first index
    always_comb begin
        n_best_d = r_best_d;
        n_best_f = r_best_f;
        n_best_s = r_best_s;
        if (w_emit) begin
            n_best_d = '1;
            n_best_f = '0;
            n_best_s = '0;
        end else if (w_d_valid) begin
            if ((r_count == CNT_W'(1)) || (w_d_dist < r_best_d) ||
                ((w_d_dist == r_best_d) && (w_d_idx < r_best_f))) begin
                n_best_d = w_d_dist;
                n_best_f = w_d_idx;
                n_best_s = r_count[IDX_W-1:0];
            end
        end
    end

    // Hold set control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_drain  <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_last   <= 1'b0;
            r_best_d <= '1;
            r_best_f <= '0;
            r_best_s <= '0;
        end else begin
            r_step   <= n_step;
            r_drain  <= n_drain;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_last   <= n_last;
            r_best_d <= n_best_d;
            r_best_f <= n_best_f;
            r_best_s <= n_best_s;
        end
    end

    // Latch the incoming point
    always_ff @(posedge i_clk) begin
        if (w_load_pt) begin
            r_nx <= i_s_axis_tdata[15:0];
            r_ny <= i_s_axis_tdata[31:16];
        end
    end

    // Pack the result; indices drop to six bits
    assign w_found      = (r_count >= CNT_W'(2));
    assign w_first_ext  = {{IDX_OUT_W{1'b0}}, r_best_f};
    assign w_second_ext = {{IDX_OUT_W{1'b0}}, r_best_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (w_found) begin
                r_out_data <= {r_ovf, w_second_ext[IDX_OUT_W-1:0],
                               w_first_ext[IDX_OUT_W-1:0], r_best_d, 1'b1};
            end else begin
                r_out_data <= {r_ovf, 47'd0};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks on the sequencer and the best-pair tracker
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_count >= CNT_W'(2)) |-> (r_best_s > r_best_f))
        else $error("best pair not in index order");

    a_dist_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_valid |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("distance result outside scan");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_count != CNT_W'(MAX_POINTS)) |=> (r_state == S_SCAN))
        else $error("stored point did not start a scan");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_count == '0 && !r_ovf && o_m_axis_tvalid))
        else $error("result did not clear the set");

endmodule

`default_nettype wire

// ===== design/cpp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpp_cell
    import cpp_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_shift,
    input  t_coord i_x,
    input  t_coord i_y,
    output t_coord o_x,
    output t_coord o_y
);

    t_coord r_x;
    t_coord r_y;

    // Take the input point (the neighbour's, or a new one at the tail) on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

// ===== design/cpp_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cpp_dist
    import cpp_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [IDX_W-1:0] i_idx,
    input  t_coord           i_ax,
    input  t_coord           i_ay,
    input  t_coord           i_bx,
    input  t_coord           i_by,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_idx,
    output t_dist            o_dist
);

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic        [SQ_W-1:0]   r_sqx;
    logic        [SQ_W-1:0]   r_sqy;
    t_dist                    r_dist;
    logic        [2:0]        r_vld;
    logic        [IDX_W-1:0]  r_idx_a;
    logic        [IDX_W-1:0]  r_idx_b;
    logic        [IDX_W-1:0]  r_idx_c;

    logic signed [2*DIFF_W-1:0] w_px;
    logic signed [2*DIFF_W-1:0] w_py;

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;

    // Advance the valid flags down the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // Difference, square, sum: one register after each
    always_ff @(posedge i_clk) begin
        r_dx    <= {i_ax[COORD_W-1], i_ax} - {i_bx[COORD_W-1], i_bx};
        r_dy    <= {i_ay[COORD_W-1], i_ay} - {i_by[COORD_W-1], i_by};
        r_idx_a <= i_idx;
        r_sqx   <= w_px[SQ_W-1:0];
        r_sqy   <= w_py[SQ_W-1:0];
        r_idx_b <= r_idx_a;
        r_dist  <= {2'b00, r_sqx} + {2'b00, r_sqy};
        r_idx_c <= r_idx_b;
    end

    assign o_valid = r_vld[2];
    assign o_idx   = r_idx_c;
    assign o_dist  = r_dist;

endmodule

`default_nettype wire

// ===== dv/closest_pair_of_points_test.sv =====
`timescale 1ns / 1ps

module closest_pair_of_points_test;
    import cpp_pkg::*;

    localparam int NUM_POINTS = 64;
    localparam int IDX_W      = IDX_OUT_W;
    localparam int TAIL_WAIT  = 4 * (NUM_POINTS + 4 + DRAIN_LEN);

    // Idling schemes, one per phase of the run
    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // How the coordinates of one random set are spread
    typedef enum int {
        SPREAD_FULL,
        SPREAD_GRID,
        SPREAD_EDGE
    } t_spread;

    // Result word, highest field first so that it maps straight onto tdata
    typedef struct packed {
        logic             overflowed;
        logic [IDX_W-1:0] second_index;
        logic [IDX_W-1:0] first_index;
        t_dist            min_sq_dist;
        logic             found;
    } t_pair_result;

    typedef struct {
        t_coord     x;
        t_coord     y;
        logic       last;
        t_idle_mode mode;
        bit         drain_first;
    } t_point_req;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data  = '0;
    logic        s_last  = 1'b0;
    logic        m_ready = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [47:0] m_data;

    closest_pair_of_points #(
        .MAX_POINTS (NUM_POINTS)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [15:0] x_coord, [31:16] y_coord
        .i_s_axis_tlast  (s_last),   // last_point
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // found, min_sq_dist, first_index,
                                     // second_index, overflowed
    );

    // Shadow copy of the point set
    t_coord x_pts [NUM_POINTS];
    t_coord y_pts [NUM_POINTS];
    int     n_pts;
    t_dist  best_dist;
    int     best_i;
    int     best_j;
    bit     dropped;

    t_pair_result pair_q [$];
    t_point_req   point_q [$];
    t_idle_mode   cur_mode    = IDLE_NONE;
    bit           point_taken = 1'b0;
    int           n_fail      = 0;

    function automatic void clear_set();
        n_pts     = 0;
        best_dist = '1;
        best_i    = 0;
        best_j    = 0;
        dropped   = 1'b0;
    endfunction

    // Fold one accepted point into the set; queue the answer on the last one
    function automatic void take_point(t_coord px, t_coord py, logic is_last);
        longint       dx;
        longint       dy;
        t_dist        d;
        t_pair_result r;
        if (n_pts < NUM_POINTS) begin
            for (int i = 0; i < n_pts; i++) begin
                dx = longint'(x_pts[i]) - longint'(px);
                dy = longint'(y_pts[i]) - longint'(py);
                d  = t_dist'(dx * dx + dy * dy);
                // earlier first index wins a tie against an older pair
                if (n_pts == 1 || d < best_dist || (d == best_dist && i < best_i)) begin
                    best_dist = d;
                    best_i    = i;
                    best_j    = n_pts;
                end
            end
            x_pts[n_pts] = px;
            y_pts[n_pts] = py;
            n_pts++;
        end else begin
            dropped = 1'b1;
        end
        if (is_last) begin
            r = '0;
            if (n_pts >= 2) begin
                r.found        = 1'b1;
                r.min_sq_dist  = best_dist;
                r.first_index  = IDX_W'(best_i);
                r.second_index = IDX_W'(best_j);
            end
            r.overflowed = dropped;
            pair_q.push_back(r);
            clear_set();
        end
    endfunction

    function automatic void add_point(int x, int y, bit last, t_idle_mode mode, bit drain);
        t_point_req p;
        p.x           = t_coord'(x);
        p.y           = t_coord'(y);
        p.last        = last;
        p.mode        = mode;
        p.drain_first = drain;
        point_q.push_back(p);
    endfunction

    function automatic int send_idle_pct(t_idle_mode mode);
        return (mode == IDLE_SEND) ? 51 : (mode == IDLE_BOTH) ? 37 : 0;
    endfunction

    function automatic int recv_idle_pct(t_idle_mode mode);
        return (mode == IDLE_RECV) ? 51 : (mode == IDLE_BOTH) ? 37 : 0;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("closest_pair_of_points_test failed");
        $finish;
    end

    // Record accepted requests in the shadow set
    always @(posedge clk) begin
        if (rst_n && s_valid && s_ready) begin
            take_point(t_coord'(s_data[15:0]), t_coord'(s_data[31:16]), s_last);
            point_taken = 1'b1;
        end
    end

    // Present the next request once the current one is taken
    always @(negedge clk) begin : drive_points
        t_point_req  nxt;
        logic        nx_valid;
        logic [31:0] nx_data;
        logic        nx_last;
        bit          hold_off;
        nx_valid = s_valid;
        nx_data  = s_data;
        nx_last  = s_last;
        if (rst_n && (!s_valid || point_taken)) begin
            point_taken = 1'b0;
            nx_valid    = 1'b0;
            if (point_q.size() != 0) begin
                // hold until the previous answers are all back
                hold_off = point_q[0].drain_first && (pair_q.size() != 0);
                if (!hold_off && $urandom_range(99) >= send_idle_pct(point_q[0].mode)) begin
                    nxt      = point_q.pop_front();
                    nx_valid = 1'b1;
                    nx_data  = {nxt.y, nxt.x};
                    nx_last  = nxt.last;
                    cur_mode = nxt.mode;
                end
            end
        end
        s_valid <= nx_valid;
        s_data  <= nx_data;
        s_last  <= nx_last;
        m_ready <= ($urandom_range(99) >= recv_idle_pct(cur_mode));
    end

    // Compare each answer with the oldest prediction
    always @(posedge clk) begin : check_results
        t_pair_result got;
        t_pair_result want;
        if (rst_n && m_valid && m_ready) begin
            got = t_pair_result'(m_data);
            if (pair_q.size() == 0) begin
                $error("result with nothing pending: %h", m_data);
                n_fail++;
            end else begin
                want = pair_q.pop_front();
                check_field("found", want.found, got.found);
                check_field("min_sq_dist", want.min_sq_dist, got.min_sq_dist);
                check_field("first_index", want.first_index, got.first_index);
                check_field("second_index", want.second_index, got.second_index);
                check_field("overflowed", want.overflowed, got.overflowed);
            end
        end
    end

    initial begin : run_test
        int         set_no;
        int         set_len;
        int         sel;
        int         x;
        int         y;
        t_spread    spread;
        t_idle_mode mode;

        clear_set();

        // single points give no pair
        add_point(0, 0, 1, IDLE_NONE, 1);
        add_point(32767, -32768, 1, IDLE_NONE, 0);
        // opposite corners: largest distance
        add_point(-32768, -32768, 0, IDLE_NONE, 0);
        add_point(32767, 32767, 1, IDLE_NONE, 0);
        // coincident points: zero distance
        add_point(100, -100, 0, IDLE_NONE, 0);
        add_point(100, -100, 1, IDLE_NONE, 0);
        // equal distances: first pair in order keeps the result
        add_point(0, 0, 0, IDLE_NONE, 0);
        add_point(256, 0, 0, IDLE_NONE, 0);
        add_point(512, 0, 0, IDLE_NONE, 0);
        add_point(0, 256, 1, IDLE_NONE, 0);
        // later pair with a smaller first index takes over a tie
        add_point(0, 0, 0, IDLE_NONE, 0);
        add_point(1000, 0, 0, IDLE_NONE, 0);
        add_point(1000, 256, 0, IDLE_NONE, 0);
        add_point(0, 256, 1, IDLE_NONE, 0);
        // three identical points
        add_point(-5, 7, 0, IDLE_NONE, 0);
        add_point(-5, 7, 0, IDLE_NONE, 0);
        add_point(-5, 7, 1, IDLE_NONE, 0);

        // random sets, mostly short, a few filling or overrunning the store
        set_no = 0;
        while (point_q.size() < 970) begin
            mode = t_idle_mode'((set_no / 6) % 4);
            sel  = $urandom_range(99);
            if (sel < 6)
                set_len = $urandom_range(60, 70);
            else if (sel < 20)
                set_len = $urandom_range(13, 40);
            else
                set_len = $urandom_range(1, 12);
            spread = t_spread'($urandom_range(2));
            for (int k = 0; k < set_len; k++) begin
                case (spread)
                    SPREAD_FULL: begin
                        x = int'($urandom_range(65535)) - 32768;
                        y = int'($urandom_range(65535)) - 32768;
                    end
                    SPREAD_GRID: begin
                        x = (int'($urandom_range(8)) - 4) * 256;
                        y = (int'($urandom_range(8)) - 4) * 256;
                    end
                    default: begin
                        x = $urandom_range(1) ? 32767 - int'($urandom_range(3))
                                              : -32768 + int'($urandom_range(3));
                        y = $urandom_range(1) ? 32767 - int'($urandom_range(3))
                                              : -32768 + int'($urandom_range(3));
                    end
                endcase
                add_point(x, y, k == set_len - 1, mode, k == 0 && (set_no % 6) == 0);
            end
            set_no++;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain the stimulus, then the answers
        while (point_q.size() != 0 || s_valid)
            @(posedge clk);
        while (pair_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (n_fail == 0)
            $display("closest_pair_of_points_test passed");
        else
            $display("closest_pair_of_points_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cpp_pkg.sv
design/cpp_cell.sv
design/cpp_dist.sv
design/closest_pair_of_points.sv
dv/closest_pair_of_points_test.sv
